[design/serel_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sector-erased ring event log: shared types and constants
// Item layouts, operation codes, status codes and the controller states.
// ----------------------------------------------------------------------------
package serel_pkg;

  // Operation codes carried by a request item.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_BEGIN  = 2'd3
  } op_t;

  // Status codes carried by a response item.
  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_NOT_STARTED = 1'b1;

  // A sequence number of all ones marks an unusable record.
  localparam logic [31:0] SEQ_INVALID = 32'hFFFF_FFFF;

  // Most records one read returns; also the value a limit of zero stands for.
  localparam logic [6:0] MAX_READ = 7'd64;

  // Request item.
  typedef struct packed {
    op_t         op;
    logic [31:0] event_time;
    logic [15:0] boot_count;
    logic [15:0] event_flags;
    logic [6:0]  read_limit;
    logic        trust_cache;
  } req_item_t;

  // Response item.
  typedef struct packed {
    logic        status;
    logic        record_found;
    logic [31:0] rec_seq;
    logic [31:0] rec_time;
    logic [15:0] rec_boot;
    logic [15:0] rec_flags;
    logic        last;
  } rsp_item_t;

  // One slot of the record store.
  typedef struct packed {
    logic        valid;
    logic [31:0] seq;
    logic [31:0] tstamp;
    logic [15:0] boot;
    logic [15:0] flags;
  } slot_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ERASE,
    ST_SCAN,
    ST_RD,
    ST_RD_FIN,
    ST_RESP
  } state_t;

endpackage
`default_nettype wire

[design/sector_erased_ring_event_log.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sector-erased ring event log
// Circular log of event records in a slot memory with one write port and
// one read port, erased a sector at a time, with rebuild on begin and newest-first readout.
// ----------------------------------------------------------------------------
// The log holds CAP = SECTORS * RECS_PER_SECTOR slots in one synchronous
// memory with a registered read, and the controller takes one request item
// at a time. After reset the block runs a clearing pass over every slot of
// the memory and accepts no item until it ends. An append that opens a
// sector also erases the rest of that sector, one slot per cycle. Clear
// sweeps every slot to invalid. A begin that rebuilds walks every slot once.
// A read walks backwards from the head one slot per cycle, but stalls while
// the response side holds a result back and a further record is found.
// Every request yields at least one response item; the final one has last
// set. Results leave through an output register, so a finished result may
// wait while the controller carries on.
// ----------------------------------------------------------------------------
module sector_erased_ring_event_log
  import serel_pkg::*;
#(
  parameter int RECS_PER_SECTOR = 16,
  parameter int SECTORS         = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  input  wire req_item_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output rsp_item_t      rsp
);

  localparam int CAP   = RECS_PER_SECTOR * SECTORS;
  localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int OFF_W = (RECS_PER_SECTOR > 1) ? $clog2(RECS_PER_SECTOR) : 1;

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAP - 1);
  localparam logic [OFF_W-1:0] OFF_LAST = OFF_W'(RECS_PER_SECTOR - 1);

  // Slot index plus one, wrapping at the end of the ring.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    idx_inc = (i == IDX_LAST) ? '0 : i + IDX_W'(1);
  endfunction

  // Slot index minus one, wrapping at the start of the ring.
  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    idx_dec = (i == '0) ? IDX_LAST : i - IDX_W'(1);
  endfunction

  // Offset within a sector plus one, wrapping at the sector end.
  function automatic logic [OFF_W-1:0] off_inc(input logic [OFF_W-1:0] o);
    off_inc = (o == OFF_LAST) ? '0 : o + OFF_W'(1);
  endfunction

  // Control registers.
  state_t           state, state_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [OFF_W-1:0] poff, poff_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] head, head_next;
  logic [OFF_W-1:0] head_off, head_off_next;
  logic [31:0]      last_seq, last_seq_next;
  logic             cache_good, cache_good_next;
  logic             started, started_next;
  logic             clr_reply, clr_reply_next;
  logic [6:0]       found_cnt, found_cnt_next;
  logic             pend_valid, pend_valid_next;
  logic             rsp_valid_next;

  // Payload registers.
  logic             resp_status, resp_status_next;
  logic [6:0]       limit, limit_next;
  rsp_item_t        pend, pend_next;
  rsp_item_t        rsp_next;

  // Memory port signals.
  slot_t            store [CAP];
  slot_t            mem_rdata;
  slot_t            mem_wdata;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;

  // Helpers for the walk states.
  logic             out_free;
  logic             slot_ok;
  rsp_item_t        slot_rec;
  rsp_item_t        empty_rsp;

  assign req_ready = (state == ST_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign slot_ok   = mem_rdata.valid && (mem_rdata.seq != SEQ_INVALID);

  // Record under the read pointer, formatted as a non-final result.
  always_comb begin
    slot_rec.status       = STATUS_OK;
    slot_rec.record_found = 1'b1;
    slot_rec.rec_seq      = mem_rdata.seq;
    slot_rec.rec_time     = mem_rdata.tstamp;
    slot_rec.rec_boot     = mem_rdata.boot;
    slot_rec.rec_flags    = mem_rdata.flags;
    slot_rec.last         = 1'b0;
  end

  // Final result without a record, carrying the pending status.
  always_comb begin
    empty_rsp.status       = resp_status;
    empty_rsp.record_found = 1'b0;
    empty_rsp.rec_seq      = '0;
    empty_rsp.rec_time     = '0;
    empty_rsp.rec_boot     = '0;
    empty_rsp.rec_flags    = '0;
    empty_rsp.last         = 1'b1;
  end

  // Slot memory: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= store[mem_raddr];
  end

  // Next state, memory accesses and result loading.
  always_comb begin
    state_next       = state;
    ptr_next         = ptr;
    poff_next        = poff;
    cnt_next         = cnt;
    head_next        = head;
    head_off_next    = head_off;
    last_seq_next    = last_seq;
    cache_good_next  = cache_good;
    started_next     = started;
    clr_reply_next   = clr_reply;
    found_cnt_next   = found_cnt;
    pend_valid_next  = pend_valid;
    resp_status_next = resp_status;
    limit_next       = limit;
    pend_next        = pend;
    rsp_valid_next   = rsp_valid && !rsp_ready;
    rsp_next         = rsp;
    mem_we           = 1'b0;
    mem_waddr        = ptr;
    mem_wdata        = '0;
    mem_raddr        = ptr;

    case (state)
      // Sweep every slot to invalid, after reset or for a clear request.
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (ptr == IDX_LAST) begin
          ptr_next   = '0;
          state_next = clr_reply ? ST_RESP : ST_IDLE;
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end

      // Take one request item and start its work.
      ST_IDLE: begin
        if (req_valid) begin
          resp_status_next = STATUS_OK;
          state_next       = ST_RESP;
          if (req.op == OP_BEGIN) begin
            started_next = 1'b1;
            if (!req.trust_cache || !cache_good) begin
              head_next     = '0;
              head_off_next = '0;
              last_seq_next = '0;
              ptr_next      = '0;
              poff_next     = '0;
              mem_raddr     = '0;
              state_next    = ST_SCAN;
            end
          end else if (!started) begin
            resp_status_next = STATUS_NOT_STARTED;
          end else begin
            case (req.op)
              OP_APPEND: begin
                mem_we          = 1'b1;
                mem_waddr       = head;
                mem_wdata.valid = 1'b1;
                mem_wdata.seq   = last_seq + 32'd1;
                mem_wdata.tstamp = req.event_time;
                mem_wdata.boot  = req.boot_count;
                mem_wdata.flags = req.event_flags;
                last_seq_next   = last_seq + 32'd1;
                head_next       = idx_inc(head);
                head_off_next   = off_inc(head_off);
                // Opening a sector erases the remaining slots of it.
                if (head_off == '0 && RECS_PER_SECTOR > 1) begin
                  ptr_next   = idx_inc(head);
                  poff_next  = OFF_W'(1);
                  state_next = ST_ERASE;
                end
              end
              OP_CLEAR: begin
                head_next       = '0;
                head_off_next   = '0;
                last_seq_next   = '0;
                cache_good_next = 1'b1;
                ptr_next        = '0;
                clr_reply_next  = 1'b1;
                state_next      = ST_CLEAR;
              end
              OP_READ: begin
                if (req.read_limit == 7'd0 || req.read_limit > MAX_READ) begin
                  limit_next = MAX_READ;
                end else begin
                  limit_next = req.read_limit;
                end
                found_cnt_next  = '0;
                pend_valid_next = 1'b0;
                cnt_next        = '0;
                mem_raddr       = idx_dec(head);
                ptr_next        = idx_dec(head);
                state_next      = ST_RD;
              end
              default: begin
                state_next = ST_RESP;
              end
            endcase
          end
        end
      end

      // Invalidate the rest of a freshly opened sector.
      ST_ERASE: begin
        mem_we = 1'b1;
        if (poff == OFF_LAST) begin
          state_next = ST_RESP;
        end else begin
          ptr_next  = ptr + IDX_W'(1);
          poff_next = poff + OFF_W'(1);
        end
      end

      // Rebuild head and last sequence from the newest usable slot.
      ST_SCAN: begin
        if (slot_ok && mem_rdata.seq > last_seq) begin
          last_seq_next = mem_rdata.seq;
          head_next     = idx_inc(ptr);
          head_off_next = off_inc(poff);
        end
        if (ptr == IDX_LAST) begin
          cache_good_next = 1'b1;
          state_next      = ST_RESP;
        end else begin
          ptr_next  = ptr + IDX_W'(1);
          poff_next = off_inc(poff);
          mem_raddr = ptr + IDX_W'(1);
        end
      end

      // Walk backwards from the head. One record is held back so the
      // final result can be marked once the walk knows it is the last.
      ST_RD: begin
        if (!(slot_ok && pend_valid && !out_free)) begin
          if (slot_ok) begin
            if (pend_valid) begin
              rsp_valid_next = 1'b1;
              rsp_next       = pend;
            end
            pend_next       = slot_rec;
            pend_valid_next = 1'b1;
            found_cnt_next  = found_cnt + 7'd1;
          end
          if (slot_ok && (found_cnt + 7'd1) == limit) begin
            state_next = ST_RD_FIN;
          end else if (cnt == IDX_LAST) begin
            state_next = ST_RD_FIN;
          end else begin
            cnt_next  = cnt + IDX_W'(1);
            ptr_next  = idx_dec(ptr);
            mem_raddr = idx_dec(ptr);
          end
        end
      end

      // Send the held record as the final result, or an empty one.
      ST_RD_FIN: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          if (pend_valid) begin
            rsp_next      = pend;
            rsp_next.last = 1'b1;
          end else begin
            rsp_next        = empty_rsp;
            rsp_next.status = STATUS_OK;
          end
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      // Single final result for append, clear, begin and refusals.
      ST_RESP: begin
        if (out_free) begin
          rsp_valid_next = 1'b1;
          rsp_next       = empty_rsp;
          clr_reply_next = 1'b0;
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      ptr        <= '0;
      poff       <= '0;
      cnt        <= '0;
      head       <= '0;
      head_off   <= '0;
      last_seq   <= '0;
      cache_good <= 1'b0;
      started    <= 1'b0;
      clr_reply  <= 1'b0;
      found_cnt  <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      ptr        <= ptr_next;
      poff       <= poff_next;
      cnt        <= cnt_next;
      head       <= head_next;
      head_off   <= head_off_next;
      last_seq   <= last_seq_next;
      cache_good <= cache_good_next;
      started    <= started_next;
      clr_reply  <= clr_reply_next;
      found_cnt  <= found_cnt_next;
      pend_valid <= pend_valid_next;
      rsp_valid  <= rsp_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    resp_status <= resp_status_next;
    limit       <= limit_next;
    pend        <= pend_next;
    rsp         <= rsp_next;
  end

`ifndef SYNTHESIS
  // The store is written only by the clearing pass, an append or a sector erase.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_CLEAR || state == ST_IDLE || state == ST_ERASE))
    else $error("slot memory written outside a write state");

  // A read never holds more records than its limit.
  a_read_limit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RD) |-> (found_cnt < limit))
    else $error("read walk passed its limit");

  // A result that carries a record always reports ok.
  a_record_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.record_found) |-> (rsp.status == STATUS_OK))
    else $error("record result with a failing status");

  // No request is taken while a read still holds a record back.
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> !req_ready)
    else $error("request accepted with a held record");

  // A new result appears only from a state that produces results.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !$past(rsp_valid)) |->
      ($past(state) == ST_RD || $past(state) == ST_RD_FIN || $past(state) == ST_RESP))
    else $error("result loaded from an unexpected state");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sector-erased ring event log: self-checking testbench
// A shadow copy of the log tracks every accepted request item and predicts
// the response items it must produce. Directed tests cover the not-started
// answers, begin with and without a trusted head, empty reads, read limits,
// field extremes, clear and sector erase on ring wrap. A back-pressure test
// and a random mix of operations follow. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import serel_pkg::*;

  localparam int RECS_PER_SECTOR = 16;
  localparam int SECTORS         = 4;
  localparam int LOG_SLOTS       = RECS_PER_SECTOR * SECTORS;
  localparam int HALF_PERIOD     = 6;
  localparam int IDLE_PERCENT    = 28;
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int REPORT_LIMIT    = 10;

  logic      clk = 1'b0;
  logic      rst;
  logic      req_valid;
  logic      req_ready;
  req_item_t req;
  logic      rsp_valid;
  logic      rsp_ready;
  rsp_item_t rsp;

  // Shadow copy of the log contents and its bookkeeping.
  logic [31:0] shadow_seq [LOG_SLOTS];
  logic [31:0] shadow_time [LOG_SLOTS];
  logic [31:0] shadow_boot_flags [LOG_SLOTS];
  bit          shadow_valid [LOG_SLOTS];
  int unsigned shadow_head;
  logic [31:0] shadow_last_seq;
  bit          shadow_cache_good;
  bit          shadow_started;

  rsp_item_t   expected_log_out[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;
  bit          steady;
  bit          hold_go;
  bit          hold_rsp;

  sector_erased_ring_event_log #(
    .RECS_PER_SECTOR(RECS_PER_SECTOR),
    .SECTORS        (SECTORS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  always #HALF_PERIOD clk = ~clk;

  // A slot holds a usable record only if it is marked and its sequence is not all ones.
  function automatic bit slot_usable(input int unsigned i);
    return shadow_valid[i] && shadow_seq[i] != SEQ_INVALID;
  endfunction

  // Find the newest usable record and place the head just after it.
  function automatic void rebuild_head();
    shadow_head     = 0;
    shadow_last_seq = '0;
    for (int unsigned i = 0; i < LOG_SLOTS; i++) begin
      if (slot_usable(i) && shadow_seq[i] > shadow_last_seq) begin
        shadow_last_seq = shadow_seq[i];
        shadow_head     = (i + 1) % LOG_SLOTS;
      end
    end
    shadow_cache_good = 1'b1;
  endfunction

  // Apply one accepted request to the shadow log and queue its responses.
  function automatic void log_model_step(input req_item_t it);
    rsp_item_t   r;
    int unsigned idx;
    int unsigned limit;
    int unsigned hits[$];
    r      = '0;
    r.last = 1'b1;
    if (it.op == OP_BEGIN) begin
      shadow_started = 1'b1;
      if (!it.trust_cache || !shadow_cache_good || shadow_head >= LOG_SLOTS) begin
        rebuild_head();
      end
      expected_log_out.push_back(r);
      return;
    end
    if (!shadow_started) begin
      r.status = STATUS_NOT_STARTED;
      expected_log_out.push_back(r);
      return;
    end
    case (it.op)
      OP_APPEND: begin
        idx = shadow_head % LOG_SLOTS;
        // Opening a sector wipes the whole sector first.
        if (idx % RECS_PER_SECTOR == 0) begin
          for (int unsigned j = 0; j < RECS_PER_SECTOR && idx + j < LOG_SLOTS; j++) begin
            shadow_valid[idx + j] = 1'b0;
          end
        end
        shadow_last_seq        = shadow_last_seq + 32'd1;
        shadow_seq[idx]        = shadow_last_seq;
        shadow_time[idx]       = it.event_time;
        shadow_boot_flags[idx] = {it.boot_count, it.event_flags};
        shadow_valid[idx]      = 1'b1;
        shadow_head            = (idx + 1) % LOG_SLOTS;
        expected_log_out.push_back(r);
      end
      OP_CLEAR: begin
        foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
        shadow_head       = 0;
        shadow_last_seq   = '0;
        shadow_cache_good = 1'b1;
        expected_log_out.push_back(r);
      end
      default: begin
        limit = it.read_limit;
        if (limit == 0 || limit > MAX_READ) limit = MAX_READ;
        // Walk backwards from the head, newest record first.
        for (int unsigned n = 1; n <= LOG_SLOTS && hits.size() < limit; n++) begin
          idx = (shadow_head % LOG_SLOTS + LOG_SLOTS - n) % LOG_SLOTS;
          if (slot_usable(idx)) hits.push_back(idx);
        end
        if (hits.size() == 0) begin
          expected_log_out.push_back(r);
        end else begin
          foreach (hits[k]) begin
            r.record_found = 1'b1;
            r.rec_seq      = shadow_seq[hits[k]];
            r.rec_time     = shadow_time[hits[k]];
            r.rec_boot     = shadow_boot_flags[hits[k]][31:16];
            r.rec_flags    = shadow_boot_flags[hits[k]][15:0];
            r.last         = (k == hits.size() - 1);
            expected_log_out.push_back(r);
          end
        end
      end
    endcase
  endfunction

  function automatic string rsp_text(input rsp_item_t r);
    return $sformatf("status=%0b found=%0b seq=%h time=%h boot=%h flags=%h last=%0b",
                     r.status, r.record_found, r.rec_seq, r.rec_time, r.rec_boot,
                     r.rec_flags, r.last);
  endfunction

  function automatic req_item_t make_req(input op_t op, input logic [31:0] t,
                                         input logic [15:0] boot, input logic [15:0] flags,
                                         input logic [6:0] limit, input logic trust);
    req_item_t it;
    it.op          = op;
    it.event_time  = t;
    it.boot_count  = boot;
    it.event_flags = flags;
    it.read_limit  = limit;
    it.trust_cache = trust;
    return it;
  endfunction

  // Random content; fields an operation ignores are randomized too.
  function automatic req_item_t rand_req(input op_t op);
    logic [6:0] limit;
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) limit = 7'($urandom_range(1, 8));
    else if (p < 75) limit = '0;
    else limit = 7'($urandom_range(0, 127));
    return make_req(op, $urandom, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), limit, 1'($urandom_range(0, 1)));
  endfunction

  function automatic op_t pick_op();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 50) return OP_APPEND;
    if (p < 75) return OP_READ;
    if (p < 83) return OP_CLEAR;
    return OP_BEGIN;
  endfunction

  // Offer one item, hold it until accepted, then update the shadow log.
  task automatic send_item(input req_item_t it);
    if (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    @(posedge clk);
    while (req_ready !== 1'b1) @(posedge clk);
    log_model_step(it);
  endtask

  // Stop offering and wait until every predicted response has arrived.
  task automatic finish_phase();
    req_valid <= 1'b0;
    while (expected_log_out.size() != 0) @(posedge clk);
    repeat (LOG_SLOTS + 8) @(posedge clk);
  endtask

  // Append, read and clear before any begin must all answer not started.
  task automatic check_not_started();
    send_item(make_req(OP_APPEND, '1, '1, '1, '1, 1'b1));
    send_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0));
    send_item(make_req(OP_CLEAR, '0, '0, '0, 7'd64, 1'b0));
    finish_phase();
  endtask

  // Trusted begin with a cold cache still rebuilds; the log reads as empty.
  task automatic check_begin_and_empty_log();
    send_item(make_req(OP_BEGIN, '0, '0, '0, '0, 1'b1));
    send_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0));
    send_item(make_req(OP_BEGIN, '1, '1, '1, '1, 1'b0));
    finish_phase();
  endtask

  task automatic check_field_extremes_and_limits();
    send_item(make_req(OP_APPEND, '0, '0, '0, '0, 1'b0));
    send_item(make_req(OP_APPEND, '1, '1, '1, '1, 1'b1));
    send_item(make_req(OP_APPEND, 32'h5555_5555, 16'hAAAA, 16'h5555, 7'h2A, 1'b0));
    send_item(make_req(OP_READ, '0, '0, '0, 7'd1, 1'b0));
    send_item(make_req(OP_READ, '0, '0, '0, 7'd64, 1'b0));
    send_item(make_req(OP_READ, '0, '0, '0, 7'd65, 1'b1));
    send_item(make_req(OP_READ, '1, '1, '1, 7'd127, 1'b1));
    send_item(make_req(OP_READ, '0, '0, '0, 7'd0, 1'b0));
    finish_phase();
  endtask

  // Clear empties the log and leaves a good cache, so a trusted begin keeps head.
  task automatic check_clear_and_trusted_begin();
    send_item(make_req(OP_CLEAR, '1, '1, '1, '1, 1'b1));
    send_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0));
    send_item(make_req(OP_BEGIN, '0, '0, '0, '0, 1'b1));
    send_item(rand_req(OP_APPEND));
    send_item(make_req(OP_READ, '0, '0, '0, '0, 1'b0));
    send_item(make_req(OP_BEGIN, '0, '0, '0, '0, 1'b0));
    send_item(make_req(OP_READ, '0, '0, '0, 7'd2, 1'b0));
    finish_phase();
  endtask

  // Fill past the ring so the oldest sector is erased, then rebuild and read.
  task automatic check_ring_wrap();
    send_item(rand_req(OP_BEGIN));
    for (int i = 0; i < LOG_SLOTS + 4; i++) send_item(rand_req(OP_APPEND));
    send_item(make_req(OP_READ, '0, '0, '0, 7'd0, 1'b0));
    send_item(make_req(OP_READ, '0, '0, '0, 7'd20, 1'b1));
    send_item(make_req(OP_BEGIN, '0, '0, '0, '0, 1'b0));
    send_item(make_req(OP_READ, '0, '0, '0, 7'd5, 1'b0));
    send_item(rand_req(OP_APPEND));
    send_item(make_req(OP_READ, '0, '0, '0, 7'd3, 1'b0));
    finish_phase();
  endtask

  // The response side stalls for a long stretch while requests keep coming.
  task automatic check_output_backpressure();
    hold_go = 1'b1;
    for (int i = 0; i < 8; i++) send_item(rand_req(OP_APPEND));
    send_item(make_req(OP_READ, '0, '0, '0, 7'd0, 1'b0));
    finish_phase();
  endtask

  // Random operations, with a stretch where neither side idles.
  task automatic check_random_mix();
    for (int i = 0; i < 24; i++) begin
      if (i == 6) steady = 1'b1;
      if (i == 18) steady = 1'b0;
      send_item(rand_req(pick_op()));
    end
    finish_phase();
  endtask

  // Long stall of the response side, counted here.
  always begin
    wait (hold_go);
    @(posedge clk);
    hold_rsp <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rsp <= 1'b0;
    hold_go = 1'b0;
  end

  // Check each accepted response item and drive the response ready.
  always @(posedge clk) begin
    rsp_item_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_ready) begin
      if (expected_log_out.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("unexpected response item: %s", rsp_text(rsp));
        end
      end else begin
        want = expected_log_out.pop_front();
        if (rsp.status !== want.status || rsp.record_found !== want.record_found ||
            rsp.rec_seq !== want.rec_seq || rsp.rec_time !== want.rec_time ||
            rsp.rec_boot !== want.rec_boot || rsp.rec_flags !== want.rec_flags ||
            rsp.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("response mismatch at cycle %0d", cycle_count);
            $display("  expected %s", rsp_text(want));
            $display("  actual   %s", rsp_text(rsp));
          end
        end
      end
    end
    rsp_ready <= !hold_rsp && (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_ready = 1'b0;
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    shadow_head       = 0;
    shadow_last_seq   = '0;
    shadow_cache_good = 1'b0;
    shadow_started    = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    check_not_started();
    check_begin_and_empty_log();
    check_field_extremes_and_limits();
    check_clear_and_trusted_begin();
    check_ring_wrap();
    check_output_backpressure();
    check_random_mix();

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/serel_pkg.sv
design/sector_erased_ring_event_log.sv
tb/tb_top.sv
